>>> sv/dgs_pkg.sv
// Package for the directed graph store: command codes, controller states,
// field widths and the command/status bundles between controller and datapath.
// No dependencies.
package dgs_pkg;

  // Default sizing
  localparam int DEF_MAX_NODES = 16;
  localparam int DEF_KEY_BITS  = 32;

  // Fixed field widths of the channels
  localparam int CMD_W      = 3;
  localparam int IN_KEY_W   = 32;
  localparam int ANS_OUT_W  = 5;
  localparam int NODE_OUT_W = 5;
  localparam int ARC_OUT_W  = 9;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_NODE  = 3'd0,
    CMD_DEL_NODE  = 3'd1,
    CMD_ADD_ARC   = 3'd2,
    CMD_DEL_ARC   = 3'd3,
    CMD_DEGREE    = 3'd4,
    CMD_ARC_POWER = 3'd5
  } cmd_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_ROW,
    ST_COUNT,
    ST_SWEEP,
    ST_DONE
  } state_e;

  // Strobes from controller to datapath
  typedef struct packed {
    logic start;       // latch a new transaction, clear search results
    logic key_scan;    // read key slot at the index
    logic add_node;    // claim the free slot for the key
    logic row_rd_a;    // read the adjacency row of the source node
    logic arc_add;     // set the arc bit if clear
    logic arc_del;     // clear the arc bit if set
    logic arc_pow;     // report arc power if the arc is present
    logic load_sh;     // load the source row into the shift register
    logic count_step;  // add one row bit to the degree
    logic sweep_rd;    // read adjacency row at the index for column clearing
    logic node_del;    // release the source slot
    logic out_load;    // move the result into the output register
  } dgs_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic a_hit;
    logic b_hit;
    logic free_hit;
  } dgs_stat_t;

endpackage

>>> sv/directed_graph_store.sv
// Top level of the directed graph store: controller plus datapath.
// Depends on dgs_pkg, dgs_ctrl and dgs_dpath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction: cmd_i, first_key_i, second_key_i. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per command:
//   ok_o, answer_o, node_total_o, arc_total_o, is_empty_o.
//   A transaction moves at a rising edge with valid high and stall low.
// Sequence, with N = MAX_NODES: each command first scans all N key slots,
//   one slot read per cycle from the key memory. Out-degree then counts
//   one row bit per cycle, and delete node reads every adjacency row,
//   one per cycle, and rewrites those that hold an arc into the node.
// Throughput: one command at a time; in_stall_o is low only while idle.
// The output register holds a finished result while the receiver stalls;
//   the next command is taken meanwhile, and its result waits until the
//   register has been emptied.
// Reset clears all slots, arcs and counts at once; no clearing pass.
module directed_graph_store import dgs_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int KEY_BITS  = DEF_KEY_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CMD_W-1:0]           cmd_i,
  input  logic signed [IN_KEY_W-1:0] first_key_i,
  input  logic signed [IN_KEY_W-1:0] second_key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic [ANS_OUT_W-1:0]       answer_o,
  output logic [NODE_OUT_W-1:0]      node_total_o,
  output logic [ARC_OUT_W-1:0]       arc_total_o,
  output logic                       is_empty_o
);

  dgs_ctrl_t                    ctrl;
  dgs_stat_t                    stat;
  logic [$clog2(MAX_NODES)-1:0] idx;

  dgs_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .idx_o       (idx)
  );

  dgs_dpath #(
    .MAX_NODES (MAX_NODES),
    .KEY_BITS  (KEY_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .idx_i        (idx),
    .stat_o       (stat),
    .cmd_i        (cmd_i),
    .first_key_i  (first_key_i),
    .second_key_i (second_key_i),
    .ok_o         (ok_o),
    .answer_o     (answer_o),
    .node_total_o (node_total_o),
    .arc_total_o  (arc_total_o),
    .is_empty_o   (is_empty_o)
  );

endmodule

>>> sv/dgs_ctrl.sv
// Controller state machine for the directed graph store.
// Sequences key scan, row access, degree count and column sweep.
// Depends on dgs_pkg.
module dgs_ctrl import dgs_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  dgs_stat_t                    stat_i,
  output dgs_ctrl_t                    ctrl_o,
  output logic [$clog2(MAX_NODES)-1:0] idx_o
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_NODES - 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  assign idx_o       = cnt_q[IDX_W-1:0];
  assign out_valid_o = out_valid_q;

  // State, step counter and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath strobes
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl_o      = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          cnt_d        = '0;
          state_d      = ST_SCAN;
        end
      end

      // Issue one key read a cycle; the final compare lands at the end step
      ST_SCAN: begin
        if (cnt_q != CNT_END) begin
          ctrl_o.key_scan = 1'b1;
          cnt_d           = cnt_q + 1'b1;
        end else begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        case (stat_i.cmd)
          CMD_ADD_NODE: begin
            ctrl_o.add_node = !stat_i.a_hit && stat_i.free_hit;
          end
          CMD_DEL_NODE, CMD_DEGREE: begin
            if (stat_i.a_hit) begin
              ctrl_o.row_rd_a = 1'b1;
              state_d         = ST_ROW;
            end
          end
          CMD_ADD_ARC, CMD_DEL_ARC, CMD_ARC_POWER: begin
            if (stat_i.a_hit && stat_i.b_hit) begin
              ctrl_o.row_rd_a = 1'b1;
              state_d         = ST_ROW;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // Source row is available from the row memory
      ST_ROW: begin
        state_d = ST_DONE;
        cnt_d   = '0;
        case (stat_i.cmd)
          CMD_ADD_ARC:   ctrl_o.arc_add = 1'b1;
          CMD_DEL_ARC:   ctrl_o.arc_del = 1'b1;
          CMD_ARC_POWER: ctrl_o.arc_pow = 1'b1;
          CMD_DEGREE: begin
            ctrl_o.load_sh = 1'b1;
            state_d        = ST_COUNT;
          end
          CMD_DEL_NODE: begin
            ctrl_o.load_sh = 1'b1;
            state_d        = ST_SWEEP;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // Count one row bit a cycle
      ST_COUNT: begin
        ctrl_o.count_step = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // Read every row once to drop the deleted node's column
      ST_SWEEP: begin
        if (cnt_q != CNT_END) begin
          ctrl_o.sweep_rd = 1'b1;
          cnt_d           = cnt_q + 1'b1;
        end else begin
          ctrl_o.node_del = 1'b1;
          state_d         = ST_DONE;
        end
      end

      // Hand the result over once the output register is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/dgs_dpath.sv
// Datapath of the directed graph store: key memory, adjacency row memory,
// slot and row valid bits, counters and the output register.
// Depends on dgs_pkg.
module dgs_dpath import dgs_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int KEY_BITS  = DEF_KEY_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dgs_ctrl_t                    ctrl_i,
  input  logic [$clog2(MAX_NODES)-1:0] idx_i,
  output dgs_stat_t                    stat_o,
  input  logic [CMD_W-1:0]             cmd_i,
  input  logic signed [IN_KEY_W-1:0]   first_key_i,
  input  logic signed [IN_KEY_W-1:0]   second_key_i,
  output logic                         ok_o,
  output logic [ANS_OUT_W-1:0]         answer_o,
  output logic [NODE_OUT_W-1:0]        node_total_o,
  output logic [ARC_OUT_W-1:0]         arc_total_o,
  output logic                         is_empty_o
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int ANS_W  = $clog2(MAX_NODES + 1);
  localparam int NODE_W = $clog2(MAX_NODES + 1);
  localparam int ARC_W  = $clog2(MAX_NODES * MAX_NODES + 1);
  localparam logic [MAX_NODES-1:0] ONE_HOT0 = {{(MAX_NODES-1){1'b0}}, 1'b1};

  // Latched transaction
  cmd_e                cmd_q;
  logic [KEY_BITS-1:0] ka_q, kb_q;
  logic [KEY_BITS-1:0] ka_in, kb_in;

  // Key memory and scan pipeline
  logic [KEY_BITS-1:0] key_mem [MAX_NODES];
  logic [KEY_BITS-1:0] key_rd_q;
  logic [IDX_W-1:0]    key_rd_idx_q;
  logic                key_rd_vld_q;

  // Search results
  logic             a_hit_q, a_hit_d, b_hit_q, b_hit_d, free_hit_q, free_hit_d;
  logic [IDX_W-1:0] a_idx_q, a_idx_d, b_idx_q, b_idx_d, free_idx_q, free_idx_d;

  // Slot and row valid bits
  logic [MAX_NODES-1:0] slot_vld_q, slot_vld_d;
  logic [MAX_NODES-1:0] row_vld_q, row_vld_d;

  // Adjacency row memory
  logic [MAX_NODES-1:0] row_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_rd_q;
  logic                 row_rd_vld_bit_q;
  logic [IDX_W-1:0]     row_rd_idx_q;
  logic                 sweep_vld_q;
  logic [MAX_NODES-1:0] row_data;
  logic                 row_re;
  logic [IDX_W-1:0]     row_raddr;
  logic                 row_we;
  logic [IDX_W-1:0]     row_waddr;
  logic [MAX_NODES-1:0] row_wdata;

  // Counting and results
  logic [MAX_NODES-1:0] sh_q, sh_d;
  logic                 ok_q, ok_d;
  logic [ANS_W-1:0]     answer_q, answer_d;
  logic [NODE_W-1:0]    node_cnt_q, node_cnt_d;
  logic [ARC_W-1:0]     arc_cnt_q, arc_cnt_d;

  logic bit_ab, bit_col, bit_out, slot_vld_rd;

  // Sign-extend or truncate the incoming keys to the stored key width
  generate
    if (KEY_BITS <= IN_KEY_W) begin : g_key_trunc
      assign ka_in = first_key_i[KEY_BITS-1:0];
      assign kb_in = second_key_i[KEY_BITS-1:0];
    end else begin : g_key_ext
      assign ka_in = {{(KEY_BITS-IN_KEY_W){first_key_i[IN_KEY_W-1]}}, first_key_i};
      assign kb_in = {{(KEY_BITS-IN_KEY_W){second_key_i[IN_KEY_W-1]}}, second_key_i};
    end
  endgenerate

  assign stat_o.cmd      = cmd_q;
  assign stat_o.a_hit    = a_hit_q;
  assign stat_o.b_hit    = b_hit_q;
  assign stat_o.free_hit = free_hit_q;

  // Latch the transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cmd_q <= cmd_e'(cmd_i);
      ka_q  <= ka_in;
      kb_q  <= kb_in;
    end
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.add_node) begin
      key_mem[free_idx_q] <= ka_q;
    end
    if (ctrl_i.key_scan) begin
      key_rd_q     <= key_mem[idx_i];
      key_rd_idx_q <= idx_i;
    end
  end

  // Compare the slot read last cycle against both keys and look for the first free slot
  assign slot_vld_rd = slot_vld_q[key_rd_idx_q];

  always_comb begin
    a_hit_d    = a_hit_q;
    a_idx_d    = a_idx_q;
    b_hit_d    = b_hit_q;
    b_idx_d    = b_idx_q;
    free_hit_d = free_hit_q;
    free_idx_d = free_idx_q;
    if (ctrl_i.start) begin
      a_hit_d    = 1'b0;
      b_hit_d    = 1'b0;
      free_hit_d = 1'b0;
    end else if (key_rd_vld_q) begin
      if (slot_vld_rd && key_rd_q == ka_q) begin
        a_hit_d = 1'b1;
        a_idx_d = key_rd_idx_q;
      end
      if (slot_vld_rd && key_rd_q == kb_q) begin
        b_hit_d = 1'b1;
        b_idx_d = key_rd_idx_q;
      end
      if (!slot_vld_rd && !free_hit_q) begin
        free_hit_d = 1'b1;
        free_idx_d = key_rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_idx_q    <= a_idx_d;
    b_idx_q    <= b_idx_d;
    free_idx_q <= free_idx_d;
  end

  // Row memory access: read the source row or the swept row
  assign row_re    = ctrl_i.row_rd_a || ctrl_i.sweep_rd;
  assign row_raddr = ctrl_i.row_rd_a ? a_idx_q : idx_i;
  assign row_data  = row_rd_vld_bit_q ? row_rd_q : '0;
  assign bit_ab    = row_data[b_idx_q];
  assign bit_col   = row_data[a_idx_q];
  assign bit_out   = sh_q[0] && (row_rd_idx_q != a_idx_q);

  // Row write port: set or clear an arc, or drop the deleted column
  always_comb begin
    row_we    = 1'b0;
    row_waddr = a_idx_q;
    row_wdata = row_data;
    if (ctrl_i.arc_add && !bit_ab) begin
      row_we    = 1'b1;
      row_wdata = row_data | (ONE_HOT0 << b_idx_q);
    end else if (ctrl_i.arc_del && bit_ab) begin
      row_we    = 1'b1;
      row_wdata = row_data & ~(ONE_HOT0 << b_idx_q);
    end else if (sweep_vld_q && bit_col) begin
      row_we    = 1'b1;
      row_waddr = row_rd_idx_q;
      row_wdata = row_data & ~(ONE_HOT0 << a_idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rd_q         <= row_mem[row_raddr];
      row_rd_vld_bit_q <= row_vld_q[row_raddr];
      row_rd_idx_q     <= row_raddr;
    end
  end

  // Valid bits, counters and result fields
  always_comb begin
    slot_vld_d = slot_vld_q;
    row_vld_d  = row_vld_q;
    node_cnt_d = node_cnt_q;
    arc_cnt_d  = arc_cnt_q;
    ok_d       = ok_q;
    answer_d   = answer_q;
    sh_d       = sh_q;

    if (ctrl_i.start) begin
      ok_d     = 1'b0;
      answer_d = '0;
    end

    if (row_we) begin
      row_vld_d[row_waddr] = 1'b1;
    end

    if (ctrl_i.add_node) begin
      slot_vld_d[free_idx_q] = 1'b1;
      row_vld_d[free_idx_q]  = 1'b0;
      node_cnt_d             = node_cnt_q + 1'b1;
      ok_d                   = 1'b1;
    end

    if (ctrl_i.arc_add && !bit_ab) begin
      arc_cnt_d = arc_cnt_q + 1'b1;
      ok_d      = 1'b1;
    end

    if (ctrl_i.arc_del && bit_ab) begin
      arc_cnt_d = arc_cnt_q - 1'b1;
      ok_d      = 1'b1;
    end

    if (ctrl_i.arc_pow && bit_ab) begin
      ok_d     = 1'b1;
      answer_d = (a_idx_q == b_idx_q) ? ANS_W'(1) : ANS_W'(2);
    end

    if (ctrl_i.load_sh) begin
      sh_d = row_data;
      ok_d = 1'b1;
    end

    // Degree: add one bit a step
    if (ctrl_i.count_step) begin
      answer_d = answer_q + ANS_W'(sh_q[0]);
      sh_d     = sh_q >> 1;
    end

    // Sweep: drop the incoming arc of this row and the outgoing arc to it
    if (sweep_vld_q) begin
      arc_cnt_d = arc_cnt_q - ARC_W'(bit_col) - ARC_W'(bit_out);
      sh_d      = sh_q >> 1;
    end

    if (ctrl_i.node_del) begin
      slot_vld_d[a_idx_q] = 1'b0;
      row_vld_d[a_idx_q]  = 1'b0;
      node_cnt_d          = node_cnt_q - 1'b1;
      ok_d                = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q   <= '0;
      row_vld_q    <= '0;
      node_cnt_q   <= '0;
      arc_cnt_q    <= '0;
      key_rd_vld_q <= 1'b0;
      sweep_vld_q  <= 1'b0;
      a_hit_q      <= 1'b0;
      b_hit_q      <= 1'b0;
      free_hit_q   <= 1'b0;
    end else begin
      slot_vld_q   <= slot_vld_d;
      row_vld_q    <= row_vld_d;
      node_cnt_q   <= node_cnt_d;
      arc_cnt_q    <= arc_cnt_d;
      key_rd_vld_q <= ctrl_i.key_scan;
      sweep_vld_q  <= ctrl_i.sweep_rd;
      a_hit_q      <= a_hit_d;
      b_hit_q      <= b_hit_d;
      free_hit_q   <= free_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    answer_q <= answer_d;
    sh_q     <= sh_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      ok_o         <= ok_q;
      answer_o     <= ANS_OUT_W'(answer_q);
      node_total_o <= NODE_OUT_W'(node_cnt_q);
      arc_total_o  <= ARC_OUT_W'(arc_cnt_q);
      is_empty_o   <= (node_cnt_q == '0);
    end
  end

endmodule

>>> sv/dgs_chk.sv
// Port-level checker for the directed graph store, bound to the top level.
// Depends on dgs_pkg.
module dgs_chk import dgs_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       ok_o,
  input logic [ANS_OUT_W-1:0]       answer_o,
  input logic [NODE_OUT_W-1:0]      node_total_o,
  input logic [ARC_OUT_W-1:0]       arc_total_o,
  input logic                       is_empty_o
);

  // Busy after every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a command is in progress");

  // A new result only appears after the block has been busy
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a command in progress");

  // Empty flag agrees with the node count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (node_total_o == '0)))
    else $error("empty flag disagrees with node count");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o) && $stable(answer_o)
      && $stable(node_total_o) && $stable(arc_total_o) && $stable(is_empty_o))
    else $error("stalled result changed");

endmodule

bind directed_graph_store dgs_chk u_dgs_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ok_o         (ok_o),
  .answer_o     (answer_o),
  .node_total_o (node_total_o),
  .arc_total_o  (arc_total_o),
  .is_empty_o   (is_empty_o)
);
